// ===== src/aabb_pkg.sv =====
// Shared widths and types for the AABB frustum cull test.
package aabb_pkg;

  localparam int COORD_BITS  = 24;                        // box corner coordinate width
  localparam int NUM_AXES    = 3;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_REGS    = 8;
  localparam int REG_ADDR_W  = $clog2(NUM_REGS);
  localparam int REG_W       = 64;                        // two matrix entries per register
  localparam int ENTRY_W     = 32;                        // signed fixed-point matrix entry
  localparam int COEF_W      = ENTRY_W + 1;               // row3 +/- rowN
  localparam int PROD_W      = COEF_W + COORD_BITS;       // coef * coordinate
  localparam int SUM_W       = PROD_W + 2;                // three products plus offset
  localparam int BOX_W       = 2 * NUM_AXES * COORD_BITS;
  localparam int IN_TDATA_W  = ((BOX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // first member sits in the highest bits: min_x lands at bit 0
  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

endpackage

// ===== src/aabb_frustum_cull_test_top.sv =====
// Top level of the AABB frustum cull test (p-vertex method).
// A request moves through three register stages (input, products, result)
// to out_*. Throughput: one box per cycle while the sink keeps taking results.
// Each stage moves when the next one is empty or drains, so a stalled result
// does not block intake while earlier stages hold bubbles.
// Reset (rst_n low, synchronous): stage valids clear, matrix registers go to zero.
module aabb_frustum_cull_test_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write port
  input  logic                                 cfg_we,
  input  logic [aabb_pkg::REG_ADDR_W-1:0]      cfg_addr,
  input  logic [aabb_pkg::REG_W-1:0]           cfg_wdata,
  // box request stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // low to high: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [aabb_pkg::IN_TDATA_W-1:0]      in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // low to high: visible, zero fill
  output logic [aabb_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import aabb_pkg::*;

  // ---------------------------------------------------------------------------
  // Matrix registers. Entry (r, c) lives in register 2r + c/2; even column in
  // the low half, odd column in the high half.
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] cfg_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Clip planes, registered: plane p = row3 + row(p/2) for even p, minus for odd.
  // Coefficients 0..2 are the normal, 3 is the offset. Config must change only
  // while idle (not enforced by the block), so the plane register lag is harmless.
  // ---------------------------------------------------------------------------
  coef_t plane_r   [NUM_PLANES][NUM_AXES+1];
  coef_t plane_nxt [NUM_PLANES][NUM_AXES+1];

  always_comb begin
    logic signed [ENTRY_W-1:0] e_row;
    logic signed [ENTRY_W-1:0] e_w;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k <= NUM_AXES; k++) begin
        e_row = (k % 2 == 1) ? cfg_r[(p / 2) * 2 + k / 2][REG_W-1 -: ENTRY_W]
                             : cfg_r[(p / 2) * 2 + k / 2][ENTRY_W-1:0];
        e_w   = (k % 2 == 1) ? cfg_r[6 + k / 2][REG_W-1 -: ENTRY_W]
                             : cfg_r[6 + k / 2][ENTRY_W-1:0];
        if (p % 2 == 1) begin
          plane_nxt[p][k] = COEF_W'(e_w) - COEF_W'(e_row);
        end else begin
          plane_nxt[p][k] = COEF_W'(e_w) + COEF_W'(e_row);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= plane_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage handshakes: a stage can load when it is empty or its content leaves.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy    = !s3_valid_r || out_tready;
  assign s2_rdy    = !s2_valid_r || s3_rdy;
  assign s1_rdy    = !s1_valid_r || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_r <= in_tvalid;
      if (s2_rdy) s2_valid_r <= s1_valid_r;
      if (s3_rdy) s3_valid_r <= s2_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: box register.
  // ---------------------------------------------------------------------------
  box_t box_r;

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) box_r <= box_t'(in_tdata[BOX_W-1:0]);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: p-vertex pick (max side when the normal component is >= 0) and
  // the 18 products, one per plane and axis.
  // ---------------------------------------------------------------------------
  coord_t box_min [NUM_AXES];
  coord_t box_max [NUM_AXES];
  prod_t  prod_r   [NUM_PLANES][NUM_AXES];
  prod_t  prod_nxt [NUM_PLANES][NUM_AXES];

  assign box_min[0] = box_r.min_x;
  assign box_min[1] = box_r.min_y;
  assign box_min[2] = box_r.min_z;
  assign box_max[0] = box_r.max_x;
  assign box_max[1] = box_r.max_y;
  assign box_max[2] = box_r.max_z;

  always_comb begin
    coord_t pv;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pv = plane_r[p][k][COEF_W-1] ? box_min[k] : box_max[k];
        prod_nxt[p][k] = PROD_W'(plane_r[p][k]) * PROD_W'(pv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid_r) prod_r <= prod_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: plane sums and sign test. Exact sums, so the sign alone decides.
  // ---------------------------------------------------------------------------
  logic visible_r, visible_nxt;

  always_comb begin
    sum_t acc;
    visible_nxt = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = SUM_W'(plane_r[p][NUM_AXES]);
      for (int k = 0; k < NUM_AXES; k++) begin
        acc = acc + SUM_W'(prod_r[p][k]);
      end
      if (acc[SUM_W-1]) visible_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_valid_r) visible_r <= visible_nxt;
  end

  assign out_tvalid = s3_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, visible_r};

endmodule

// ===== src/aabb_checker.sv =====
// Port-level checker for the AABB frustum cull test, bound to the top level.
module aabb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [aabb_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import aabb_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with no result pending every stage can move, so intake is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("intake blocked with empty output");

  // an accepted request reaches the output when the sink keeps taking
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing after pipeline latency");

  // fill bits above the visible flag stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("nonzero fill bits in result");

endmodule

bind aabb_frustum_cull_test_top aabb_checker u_aabb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
